[hw/rtl/sem_pkg.sv]
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared widths, state encodings, register codes and the front/back queue
// entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

    localparam int PIX_W  = 8;
    localparam int COL_W  = 11;
    localparam int ROW_W  = 12;
    localparam int CFG_W  = 12;
    localparam int MAG_W  = 8;
    localparam int ABS_W  = 10;   // |gx|, |gy| never exceed 1020
    localparam int SQ_W   = 20;
    localparam int SUM_W  = 21;
    localparam int ROOT_W = 8;
    localparam int BIT_IDX_W = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QAW         = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [CFG_W-1:0] MIN_DIM      = 12'd3;

    // register index carried by paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [2:0][2:0][PIX_W-1:0] window_t;

    typedef struct packed {
        window_t          window;
        logic [ROW_W-1:0] centre_row;
        logic [COL_W-1:0] centre_column;
        logic             frame_done;
    } entry_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

    typedef enum logic {
        F_IDLE,
        F_UPDATE
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_GRAD,
        B_SQUARE,
        B_SUM,
        B_ROOT,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

[hw/rtl/sobel_edge_magnitude.sv]
// Input: each pixel is accepted with a line store read, then written back before the
// next pixel is taken; a full window queue holds the write-back of an interior pixel.
// Results: one window at a time; the square root in the back end takes one bit per cycle.
// A two-entry window queue lets border pixels flow at input rate while results drain.
// Reset (aresetn low, synchronous) clears counters, window, queue, FSMs and config
// (640 x 480); line store contents are left as they are.
// ----------------------------------------------------------------------------
// Sobel edge magnitude
// Streaming 3x3 Sobel gradient magnitude with an APB register port.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [2:0]                    paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [sem_pkg::PIX_W-1:0]     s_pixel_value,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [sem_pkg::MAG_W-1:0]    m_edge_magnitude,
    output logic [sem_pkg::ROW_W-1:0]    m_centre_row,
    output logic [sem_pkg::COL_W-1:0]    m_centre_column,
    output logic                         m_frame_done
);

    logic [sem_pkg::CFG_W-1:0] width_reg;
    logic [sem_pkg::CFG_W-1:0] height_reg;
    logic                      cfg_write;

    sem_pkg::q_status_t q_status;
    sem_pkg::entry_t    push_entry;
    sem_pkg::entry_t    head;
    logic               push;
    logic               pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= sem_pkg::WIDTH_RESET;
            height_reg <= sem_pkg::HEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                sem_pkg::REG_WIDTH:  width_reg  <= pwdata[sem_pkg::CFG_W-1:0];
                sem_pkg::REG_HEIGHT: height_reg <= pwdata[sem_pkg::CFG_W-1:0];
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            sem_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            sem_pkg::REG_HEIGHT: prdata = 32'(height_reg);
            default:             prdata = '0;
        endcase
    end

    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .cfg_width     (width_reg),
        .cfg_height    (height_reg),
        .q_status      (q_status),
        .push          (push),
        .push_entry    (push_entry)
    );

    sem_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .status     (q_status),
        .head       (head)
    );

    sem_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_status         (q_status),
        .head             (head),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_edge_magnitude (m_edge_magnitude),
        .m_centre_row     (m_centre_row),
        .m_centre_column  (m_centre_column),
        .m_frame_done     (m_frame_done)
    );

endmodule

`default_nettype wire

[hw/rtl/sem_front.sv]
// ----------------------------------------------------------------------------
// Sobel front end
// Accepts pixels, tracks raster position, keeps the two line stores and the
// 3x3 window, and queues a window for every pixel that completes one.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [sem_pkg::PIX_W-1:0]     s_pixel_value,
    input  wire [sem_pkg::CFG_W-1:0]     cfg_width,
    input  wire [sem_pkg::CFG_W-1:0]     cfg_height,
    input  wire sem_pkg::q_status_t      q_status,
    output logic                         push,
    output sem_pkg::entry_t              push_entry
);

    localparam int AW = $clog2(MAX_WIDTH);

    sem_pkg::front_state_t state_reg, state_next;

    logic [sem_pkg::COL_W-1:0] col_reg, col_next;
    logic [sem_pkg::ROW_W-1:0] row_reg, row_next;
    logic [sem_pkg::PIX_W-1:0] pix_reg;
    logic [sem_pkg::PIX_W-1:0] up_rd_reg;
    logic [sem_pkg::PIX_W-1:0] mid_rd_reg;
    sem_pkg::window_t          win_reg, win_next;

    logic [sem_pkg::PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [sem_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];

    logic [AW-1:0]             addr;
    logic                      in_range;
    logic [sem_pkg::CFG_W-1:0] eff_width;
    logic [sem_pkg::CFG_W-1:0] eff_height;
    logic [sem_pkg::COL_W:0]   col_plus;
    logic [sem_pkg::ROW_W:0]   row_plus;
    logic                      row_end;
    logic                      frame_end;
    logic                      has_result;
    logic [sem_pkg::PIX_W-1:0] up_val;
    logic [sem_pkg::PIX_W-1:0] mid_val;
    logic                      accept;
    logic                      advance;

    assign addr     = AW'(col_reg);
    assign in_range = (32'(col_reg) < MAX_WIDTH);

    always_comb begin
        if (cfg_width < sem_pkg::MIN_DIM) begin
            eff_width = sem_pkg::MIN_DIM;
        end else if (32'(cfg_width) > MAX_WIDTH) begin
            eff_width = sem_pkg::CFG_W'(MAX_WIDTH);
        end else begin
            eff_width = cfg_width;
        end
        eff_height = (cfg_height < sem_pkg::MIN_DIM) ? sem_pkg::MIN_DIM : cfg_height;
    end

    assign col_plus   = {1'b0, col_reg} + 12'd1;
    assign row_plus   = {1'b0, row_reg} + 13'd1;
    assign row_end    = (col_plus >= eff_width);
    assign frame_end  = row_end && (row_plus >= {1'b0, eff_height});
    assign has_result = (row_reg >= 12'd2) && (col_reg >= 11'd2);

    always_comb begin
        if (frame_end) begin
            col_next = '0;
            row_next = '0;
        end else if (row_end) begin
            col_next = '0;
            row_next = row_plus[sem_pkg::ROW_W-1:0];
        end else begin
            col_next = col_plus[sem_pkg::COL_W-1:0];
            row_next = row_reg;
        end
    end

    assign up_val  = in_range ? up_rd_reg  : '0;
    assign mid_val = in_range ? mid_rd_reg : '0;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = up_val;
        win_next[1][2] = mid_val;
        win_next[2][2] = pix_reg;
    end

    assign push_entry.window        = win_next;
    assign push_entry.centre_row    = row_reg - 12'd1;
    assign push_entry.centre_column = col_reg - 11'd1;
    assign push_entry.frame_done    = frame_end;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sem_pkg::F_IDLE:   if (s_valid) state_next = sem_pkg::F_UPDATE;
            sem_pkg::F_UPDATE: if (advance) state_next = sem_pkg::F_IDLE;
            default:           state_next = sem_pkg::F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = 1'b0;
        advance = 1'b0;
        unique case (state_reg)
            sem_pkg::F_IDLE:   s_ready = 1'b1;
            sem_pkg::F_UPDATE: advance = !has_result || !q_status.full;
            default:           s_ready = 1'b0;
        endcase
        push = advance && has_result;
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sem_pkg::F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            win_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (advance) begin
                col_reg <= col_next;
                row_reg <= row_next;
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg <= s_pixel_value;
        end
    end

    // read the column on accept, write it back when the update advances
    always_ff @(posedge aclk) begin
        if (accept) begin
            up_rd_reg <= upper_mem[addr];
        end
        if (advance && in_range) begin
            upper_mem[addr] <= mid_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mid_rd_reg <= middle_mem[addr];
        end
        if (advance && in_range) begin
            middle_mem[addr] <= pix_reg;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sem_queue.sv]
// ----------------------------------------------------------------------------
// Sobel window queue
// Short FIFO of complete windows between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_queue (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     push,
    input  wire sem_pkg::entry_t    push_entry,
    input  wire                     pop,
    output sem_pkg::q_status_t      status,
    output sem_pkg::entry_t         head
);

    sem_pkg::entry_t          slot_reg [sem_pkg::QUEUE_DEPTH];
    logic [sem_pkg::QAW-1:0]  wr_ptr_reg;
    logic [sem_pkg::QAW-1:0]  rd_ptr_reg;
    logic [sem_pkg::QAW:0]    count_reg;
    logic                     do_push;
    logic                     do_pop;

    assign status.full      = (count_reg == (sem_pkg::QAW+1)'(sem_pkg::QUEUE_DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign head             = slot_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && status.not_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sem_back.sv]
// ----------------------------------------------------------------------------
// Sobel back end
// Pops a window, forms gx and gy, squares and sums them, takes the floor
// square root one bit per cycle, saturating, and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_back (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire sem_pkg::q_status_t      q_status,
    input  wire sem_pkg::entry_t         head,
    output logic                         pop,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [sem_pkg::MAG_W-1:0]    m_edge_magnitude,
    output logic [sem_pkg::ROW_W-1:0]    m_centre_row,
    output logic [sem_pkg::COL_W-1:0]    m_centre_column,
    output logic                         m_frame_done
);

    sem_pkg::back_state_t state_reg, state_next;

    sem_pkg::entry_t                 ent_reg;
    logic [sem_pkg::ABS_W-1:0]       absx_reg;
    logic [sem_pkg::ABS_W-1:0]       absy_reg;
    logic [sem_pkg::SQ_W-1:0]        sqx_reg;
    logic [sem_pkg::SQ_W-1:0]        sqy_reg;
    logic [sem_pkg::SUM_W-1:0]       sum_reg;
    logic [sem_pkg::ROOT_W-1:0]      root_reg;
    logic [sem_pkg::BIT_IDX_W-1:0]   bit_idx_reg;

    logic                            m_valid_reg;
    logic [sem_pkg::MAG_W-1:0]       mag_out_reg;
    logic [sem_pkg::ROW_W-1:0]       row_out_reg;
    logic [sem_pkg::COL_W-1:0]       col_out_reg;
    logic                            fd_out_reg;

    logic                            load_out;
    logic [9:0]                      pos_x, neg_x, pos_y, neg_y;
    logic signed [10:0]              gx, gy;
    logic [sem_pkg::ROOT_W-1:0]      trial;
    logic [2*sem_pkg::ROOT_W-1:0]    trial_sq;
    logic                            saturate;

    // window is [row][col]; middle taps count twice
    always_comb begin
        pos_x = 10'(ent_reg.window[0][2]) + {1'b0, ent_reg.window[1][2], 1'b0}
              + 10'(ent_reg.window[2][2]);
        neg_x = 10'(ent_reg.window[0][0]) + {1'b0, ent_reg.window[1][0], 1'b0}
              + 10'(ent_reg.window[2][0]);
        pos_y = 10'(ent_reg.window[0][0]) + {1'b0, ent_reg.window[0][1], 1'b0}
              + 10'(ent_reg.window[0][2]);
        neg_y = 10'(ent_reg.window[2][0]) + {1'b0, ent_reg.window[2][1], 1'b0}
              + 10'(ent_reg.window[2][2]);
        gx = $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
        gy = $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
    end

    assign trial    = root_reg | (sem_pkg::ROOT_W'(1) << bit_idx_reg);
    assign trial_sq = trial * trial;
    assign saturate = |sum_reg[sem_pkg::SUM_W-1:2*sem_pkg::ROOT_W];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sem_pkg::B_IDLE:   if (q_status.not_empty) state_next = sem_pkg::B_GRAD;
            sem_pkg::B_GRAD:   state_next = sem_pkg::B_SQUARE;
            sem_pkg::B_SQUARE: state_next = sem_pkg::B_SUM;
            sem_pkg::B_SUM:    state_next = sem_pkg::B_ROOT;
            sem_pkg::B_ROOT:   if (bit_idx_reg == '0) state_next = sem_pkg::B_DONE;
            sem_pkg::B_DONE:   if (!m_valid_reg || m_ready) state_next = sem_pkg::B_IDLE;
            default:           state_next = sem_pkg::B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        pop      = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            sem_pkg::B_IDLE: pop      = q_status.not_empty;
            sem_pkg::B_DONE: load_out = !m_valid_reg || m_ready;
            default: begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sem_pkg::B_IDLE;
            bit_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == sem_pkg::B_SUM) begin
                bit_idx_reg <= sem_pkg::BIT_IDX_W'(sem_pkg::ROOT_W - 1);
            end else if (state_reg == sem_pkg::B_ROOT) begin
                bit_idx_reg <= bit_idx_reg - 1'b1;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            ent_reg <= head;
        end
        if (state_reg == sem_pkg::B_GRAD) begin
            absx_reg <= gx[10] ? sem_pkg::ABS_W'(-gx) : sem_pkg::ABS_W'(gx);
            absy_reg <= gy[10] ? sem_pkg::ABS_W'(-gy) : sem_pkg::ABS_W'(gy);
        end
        if (state_reg == sem_pkg::B_SQUARE) begin
            sqx_reg <= absx_reg * absx_reg;
            sqy_reg <= absy_reg * absy_reg;
        end
        if (state_reg == sem_pkg::B_SUM) begin
            sum_reg  <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            root_reg <= '0;
        end
        // keep the trial bit when its square still fits
        if (state_reg == sem_pkg::B_ROOT) begin
            if (trial_sq <= sum_reg[2*sem_pkg::ROOT_W-1:0]) begin
                root_reg <= trial;
            end
        end
        if (load_out) begin
            mag_out_reg <= saturate ? '1 : root_reg;
            row_out_reg <= ent_reg.centre_row;
            col_out_reg <= ent_reg.centre_column;
            fd_out_reg  <= ent_reg.frame_done;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_edge_magnitude = mag_out_reg;
    assign m_centre_row     = row_out_reg;
    assign m_centre_column  = col_out_reg;
    assign m_frame_done     = fd_out_reg;

endmodule

`default_nettype wire

[hw/rtl/sem_checker.sv]
// ----------------------------------------------------------------------------
// Sobel edge magnitude port checker
// Port-level properties of the pixel and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_checker (
    input wire                        aclk,
    input wire                        aresetn,
    input wire                        s_valid,
    input wire                        s_ready,
    input wire                        m_valid,
    input wire                        m_ready,
    input wire [sem_pkg::MAG_W-1:0]   m_edge_magnitude,
    input wire [sem_pkg::ROW_W-1:0]   m_centre_row,
    input wire [sem_pkg::COL_W-1:0]   m_centre_column,
    input wire                        m_frame_done
);

    // a stalled result holds valid and payload
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_edge_magnitude)
            && $stable(m_centre_row) && $stable(m_centre_column) && $stable(m_frame_done))
        else $error("result changed while stalled");

    // results only ever name interior pixels
    a_interior_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_centre_row != '0 && m_centre_column != '0)
        else $error("result on a border position");

    // s_ready is low in the cycle after each accepted pixel, while the line store write-back is pending
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("pixel accepted during write-back");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (.*);

`default_nettype wire
